// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// next-cycle implication, reset masked
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// File: hw/rtl/spq_pkg.sv
package spq_pkg;

  // fixed data widths
  localparam int XW = 62;
  localparam int GUARD_BITS = 16;
  localparam int MAX_SIDE = 4096;
  localparam int ANGLE_FRAC_BITS_DEF = 24;
  localparam int AMP_QW = 17;
  localparam logic [31:0] KINV_Q32 = 32'h9B74EDA8;

  // register map
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_CENTERED_ORDER = 2'd2,
    REG_INVERSE_MODE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] dcol;
    logic [11:0] drow;
    logic        zero;
  } side_t;

  typedef struct packed {
    side_t                 side;
    logic                  flag;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
  } pay_t;

  // pi/4 in q60 from the machin series
  function automatic logic [63:0] quarter_pi_q60();
    logic [63:0] t5;
    logic [63:0] s5;
    logic [63:0] t239;
    logic [63:0] s239;
    logic [63:0] term;
    logic        neg;
    logic        done;
    t5 = (64'd1 << 60) / 64'd5;
    s5 = t5;
    neg = 1'b1;
    done = 1'b0;
    for (int m = 1; m < 64; m++) begin
      if (!done) begin
        t5 = t5 / 64'd25;
        if (t5 == 64'd0) begin
          done = 1'b1;
        end else begin
          term = t5 / 64'(2 * m + 1);
          s5 = neg ? s5 - term : s5 + term;
          neg = !neg;
        end
      end
    end
    t239 = (64'd1 << 60) / 64'd239;
    s239 = t239;
    neg = 1'b1;
    done = 1'b0;
    for (int m = 1; m < 64; m++) begin
      if (!done) begin
        t239 = t239 / 64'd57121;
        if (t239 == 64'd0) begin
          done = 1'b1;
        end else begin
          term = t239 / 64'(2 * m + 1);
          s239 = neg ? s239 - term : s239 + term;
          neg = !neg;
        end
      end
    end
    return 64'd4 * s5 - s239;
  endfunction

  // atan(2^-k) in q60, k >= 1
  function automatic logic [63:0] atan_pow2_q60(input int k);
    logic [63:0] sum;
    logic [63:0] term;
    logic        neg;
    sum = 64'd0;
    neg = 1'b0;
    for (int m = 0; m < 32; m++) begin
      if (k * (2 * m + 1) <= 60) begin
        term = (64'd1 << (60 - k * (2 * m + 1))) / 64'(2 * m + 1);
        sum = neg ? sum - term : sum + term;
        neg = !neg;
      end
    end
    return sum;
  endfunction

  // q60 to angle format, round to nearest
  function automatic logic [63:0] af_round(input logic [63:0] q, input int af);
    return (q + (64'd1 << (59 - af))) >> (60 - af);
  endfunction

  function automatic logic [63:0] atan_af(input int idx, input int af);
    return (idx == 0) ? af_round(quarter_pi_q60(), af) : af_round(atan_pow2_q60(idx), af);
  endfunction

  // drop guard bits with half-up rounding, saturate to 41 bits
  function automatic logic [40:0] round_out41(input logic signed [XW-1:0] v);
    logic signed [XW:0] s;
    logic [XW-GUARD_BITS:0] r;
    s = $signed({v[XW-1], v}) + $signed((XW+1)'(1 << (GUARD_BITS - 1)));
    r = s[XW:GUARD_BITS];
    if (r[XW-GUARD_BITS:40] == '0 || r[XW-GUARD_BITS:40] == '1) begin
      return r[40:0];
    end else if (r[XW-GUARD_BITS]) begin
      return {1'b1, 40'd0};
    end else begin
      return {1'b0, {40{1'b1}}};
    end
  endfunction

endpackage

// File: hw/rtl/spq_div_cell.sv
// one restoring-division step: decides quotient bit BIT
module spq_div_cell #(
  parameter int BIT = 0,
  parameter int QW  = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [63:0]          in_rem,
  input  logic [QW-1:0]        in_q,
  input  logic [63:0]          divisor,
  input  spq_pkg::pay_t        in_pay,
  output logic                 out_valid,
  output logic [63:0]          out_rem,
  output logic [QW-1:0]        out_q,
  output spq_pkg::pay_t        out_pay
);

  logic [63:0]   sub;
  logic          ge;
  logic [QW-1:0] q_next;

  // compare against the shifted divisor
  always_comb begin
    sub = divisor << BIT;
    ge = (in_rem >= sub);
    q_next = in_q;
    q_next[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem <= ge ? in_rem - sub : in_rem;
      out_q <= q_next;
      out_pay <= in_pay;
    end
  end

endmodule

// File: hw/rtl/spq_cordic_cell.sv
// one cordic micro-rotation, vectoring in forward mode, rotation in inverse
module spq_cordic_cell #(
  parameter int IDX = 0,
  parameter int AF  = 24,
  parameter int ZW  = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 inv,
  input  logic                 in_valid,
  input  spq_pkg::pay_t        in_pay,
  input  logic signed [ZW-1:0] in_z,
  output logic                 out_valid,
  output spq_pkg::pay_t        out_pay,
  output logic signed [ZW-1:0] out_z
);

  localparam logic [63:0] ATAN_AF = spq_pkg::atan_af(IDX, AF);
  localparam logic signed [ZW-1:0] ATAN_Z = $signed(ZW'(ATAN_AF));

  logic signed [spq_pkg::XW-1:0] xs;
  logic signed [spq_pkg::XW-1:0] ys;
  logic                          rot;
  spq_pkg::pay_t                 pay_next;
  logic signed [ZW-1:0]          z_next;

  // direction: drive y to zero, or z to zero
  always_comb begin
    xs = in_pay.x >>> IDX;
    ys = in_pay.y >>> IDX;
    rot = inv ? !in_z[ZW-1] : in_pay.y[spq_pkg::XW-1];
    pay_next = in_pay;
    if (rot) begin
      pay_next.x = in_pay.x - ys;
      pay_next.y = in_pay.y + xs;
      z_next = in_z - ATAN_Z;
    end else begin
      pay_next.x = in_pay.x + ys;
      pay_next.y = in_pay.y - xs;
      z_next = in_z + ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pay <= pay_next;
      out_z <= z_next;
    end
  end

endmodule

// File: hw/rtl/spectrum_polar_quantizer_top.sv
// channel   | handshake           | payload
// config    | psel/penable/pready | paddr, pwdata, prdata
// input     | in_valid/in_stall   | column, row, real_part, imag_part, words in
// output    | out_valid/out_stall | dest_column, dest_row, words out, real/imag out
//
// one item per cycle unless the output stalls; the path runs through the cordic cell row,
// the 17-step amplitude divider row and ten single stages.
// the whole pipe advances together; a stalled output holds every stage and
// raises in_stall. synchronous reset clears the valid bits and loads the configuration defaults.
`include "assert_macros.svh"

module spectrum_polar_quantizer_top #(
  parameter int ANGLE_FRAC_BITS = spq_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        column,
  input  logic [11:0]        row,
  input  logic signed [40:0] real_part,
  input  logic signed [40:0] imag_part,
  input  logic [15:0]        amplitude_word_in,
  input  logic [15:0]        phase_word_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        dest_column,
  output logic [11:0]        dest_row,
  output logic [15:0]        amplitude_word_out,
  output logic [15:0]        phase_word_out,
  output logic signed [40:0] real_out,
  output logic signed [40:0] imag_out
);

  localparam int AF = ANGLE_FRAC_BITS;
  localparam int XW = spq_pkg::XW;
  localparam int ZW = AF + 4;
  localparam int DZ = AF + 3;
  localparam int QW = spq_pkg::AMP_QW;
  localparam logic [63:0] QPI = spq_pkg::quarter_pi_q60();
  localparam logic [63:0] PI_AF = spq_pkg::af_round(QPI << 2, AF);
  localparam logic [63:0] HALFPI_AF = spq_pkg::af_round(QPI << 1, AF);
  localparam logic [63:0] TWOPI_AF = spq_pkg::af_round(QPI << 3, AF);
  localparam logic signed [ZW-1:0] PI_Z = $signed(ZW'(PI_AF));
  localparam logic signed [ZW-1:0] HP_Z = $signed(ZW'(HALFPI_AF));
  localparam logic [63:0] PH_RECIP = (64'd1 << (AF + 23)) / TWOPI_AF;
  localparam logic [11:0] SIDE_MASK = 12'(spq_pkg::MAX_SIDE - 1);

  // configuration registers
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic        centered_order;
  logic        inverse_mode;
  logic [12:0] wf;
  logic [12:0] hf;
  logic [25:0] wh;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 13'd1024;
      frame_height <= 13'd1024;
      centered_order <= 1'b1;
      inverse_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (spq_pkg::reg_idx_t'(paddr[3:2]))
        spq_pkg::REG_FRAME_WIDTH:    frame_width <= pwdata[12:0];
        spq_pkg::REG_FRAME_HEIGHT:   frame_height <= pwdata[12:0];
        spq_pkg::REG_CENTERED_ORDER: centered_order <= pwdata[0];
        spq_pkg::REG_INVERSE_MODE:   inverse_mode <= pwdata[0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (spq_pkg::reg_idx_t'(paddr[3:2]))
      spq_pkg::REG_FRAME_WIDTH:    prdata = 32'(frame_width);
      spq_pkg::REG_FRAME_HEIGHT:   prdata = 32'(frame_height);
      spq_pkg::REG_CENTERED_ORDER: prdata = 32'(centered_order);
      spq_pkg::REG_INVERSE_MODE:   prdata = 32'(inverse_mode);
    endcase
  end

  // zero size counts as one
  assign wf = (frame_width == 13'd0) ? 13'd1 : frame_width;
  assign hf = (frame_height == 13'd0) ? 13'd1 : frame_height;

  always_ff @(posedge clk) begin
    wh <= wf * hf;
  end

  // whole pipe moves unless the output is held
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input stage: coordinate swap, guard-bit scaling or amplitude-width product, angle numerator
  logic [11:0]   half_c;
  logic [11:0]   half_r;
  logic [12:0]   col_sum;
  logic [12:0]   row_sum;
  logic [28:0]   aw_w;
  spq_pkg::pay_t s0_in;
  logic [63:0]   s0_rem_in;
  logic          s0_valid;
  spq_pkg::pay_t s0_pay;
  logic [63:0]   s0_rem;

  always_comb begin
    half_c = frame_width[12:1];
    half_r = frame_height[12:1];
    col_sum = (column < half_c) ? 13'(column) + 13'(half_c) : 13'(column - half_c);
    row_sum = (row < half_r) ? 13'(row) + 13'(half_r) : 13'(row - half_r);
    aw_w = amplitude_word_in * wf;
    s0_in.side.dcol = centered_order ? (col_sum[11:0] & SIDE_MASK) : column;
    s0_in.side.drow = centered_order ? (row_sum[11:0] & SIDE_MASK) : row;
    s0_in.side.zero = (real_part == '0) && (imag_part == '0);
    s0_in.flag = 1'b0;
    if (inverse_mode) begin
      s0_in.x = $signed(XW'(aw_w));
      s0_in.y = '0;
    end else begin
      s0_in.x = $signed({{(XW-57){real_part[40]}}, real_part, 16'd0});
      s0_in.y = $signed({{(XW-57){imag_part[40]}}, imag_part, 16'd0});
    end
    s0_rem_in = 64'(phase_word_in) * TWOPI_AF + 64'd32767;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_pay <= s0_in;
      s0_rem <= s0_rem_in;
    end
  end

  // phase word to angle: divide by 65535 by folding 16-bit digits
  logic          zq_valid;
  spq_pkg::pay_t zq_pay;
  logic [DZ-1:0] zq_q;
  logic [63:0]   zq_s;
  logic [63:0]   zq_acc;
  logic [DZ-1:0] zq_q_in;

  always_comb begin
    zq_s = s0_rem;
    zq_acc = '0;
    for (int j = 0; j < 3; j++) begin
      zq_acc = zq_acc + (zq_s >> 16);
      zq_s = (zq_s >> 16) + {48'd0, zq_s[15:0]};
    end
    zq_q_in = DZ'(zq_acc + ((zq_s >= 64'd65535) ? 64'd1 : 64'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zq_valid <= 1'b0;
    end else if (adv) begin
      zq_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zq_pay <= s0_pay;
      zq_q <= zq_q_in;
    end
  end

  // inverse: full magnitude product and centered angle
  logic                 m1_valid;
  spq_pkg::pay_t        m1_pay;
  spq_pkg::pay_t        m1_pay_next;
  logic signed [ZW-1:0] m1_z;
  logic [41:0]          m_full;

  assign m_full = zq_pay.x[28:0] * hf;

  always_comb begin
    m1_pay_next = zq_pay;
    if (inverse_mode) begin
      m1_pay_next.x = $signed(XW'(m_full));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= zq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_pay <= m1_pay_next;
      m1_z <= $signed({1'b0, zq_q}) - PI_Z;
    end
  end

  // inverse: gain correction split into two 32-bit products
  logic                 m2_valid;
  spq_pkg::pay_t        m2_pay;
  spq_pkg::pay_t        m2_pay_next;
  logic signed [ZW-1:0] m2_z;
  logic [41:0]          inv_phi;
  logic [63:0]          inv_plo;

  assign inv_phi = m1_pay.x[41:32] * spq_pkg::KINV_Q32;
  assign inv_plo = m1_pay.x[31:0] * spq_pkg::KINV_Q32;

  always_comb begin
    m2_pay_next = m1_pay;
    if (inverse_mode) begin
      m2_pay_next.y = $signed(XW'(inv_phi));
      m2_pay_next.x = $signed(XW'(inv_plo[63:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_pay <= m2_pay_next;
      m2_z <= m1_z;
    end
  end

  // quadrant pre-rotation
  logic                 pr_valid;
  spq_pkg::pay_t        pr_pay;
  logic signed [ZW-1:0] pr_z;
  spq_pkg::pay_t        pr_in;
  logic signed [ZW-1:0] pr_z_in;
  logic [57:0]          mag;

  always_comb begin
    pr_in = m2_pay;
    mag = {m2_pay.y[41:0], 16'd0} + 58'(m2_pay.x[47:0]);
    pr_z_in = '0;
    if (inverse_mode) begin
      if (m2_z > HP_Z) begin
        pr_in.x = '0;
        pr_in.y = $signed(XW'(mag));
        pr_z_in = m2_z - HP_Z;
      end else if (m2_z < -HP_Z) begin
        pr_in.x = '0;
        pr_in.y = -$signed(XW'(mag));
        pr_z_in = m2_z + HP_Z;
      end else begin
        pr_in.x = $signed(XW'(mag));
        pr_in.y = '0;
        pr_z_in = m2_z;
      end
    end else if (m2_pay.x[XW-1]) begin
      if (!m2_pay.y[XW-1]) begin
        pr_in.x = m2_pay.y;
        pr_in.y = -m2_pay.x;
        pr_z_in = HP_Z;
      end else begin
        pr_in.x = -m2_pay.y;
        pr_in.y = m2_pay.x;
        pr_z_in = -HP_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (adv) begin
      pr_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_pay <= pr_in;
      pr_z <= pr_z_in;
    end
  end

  // cordic cell row
  logic                 cc_valid [AF+1];
  spq_pkg::pay_t        cc_pay   [AF+1];
  logic signed [ZW-1:0] cc_z     [AF+1];

  assign cc_valid[0] = pr_valid;
  assign cc_pay[0] = pr_pay;
  assign cc_z[0] = pr_z;

  for (genvar i = 0; i < AF; i++) begin : g_cordic
    spq_cordic_cell #(
      .IDX (i),
      .AF  (AF),
      .ZW  (ZW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .inv       (inverse_mode),
      .in_valid  (cc_valid[i]),
      .in_pay    (cc_pay[i]),
      .in_z      (cc_z[i]),
      .out_valid (cc_valid[i+1]),
      .out_pay   (cc_pay[i+1]),
      .out_z     (cc_z[i+1])
    );
  end

  // forward: gain products and offset angle
  logic                 k_valid;
  spq_pkg::pay_t        k_pay;
  spq_pkg::pay_t        k_pay_next;
  logic signed [ZW:0]   k_t;
  logic [61:0]          fw_phi;
  logic [63:0]          fw_plo;
  logic signed [ZW-1:0] z_sel;
  logic signed [ZW:0]   t_in;

  always_comb begin
    fw_phi = cc_pay[AF].x[XW-1:32] * spq_pkg::KINV_Q32;
    fw_plo = cc_pay[AF].x[31:0] * spq_pkg::KINV_Q32;
    z_sel = cc_pay[AF].side.zero ? '0 : cc_z[AF];
    t_in = $signed({z_sel[ZW-1], z_sel}) + $signed({1'b0, PI_Z});
    k_pay_next = cc_pay[AF];
    if (!inverse_mode) begin
      k_pay_next.y = $signed(XW'(fw_phi));
      k_pay_next.x = $signed(XW'(fw_plo[63:32]));
      k_pay_next.flag = t_in[ZW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else if (adv) begin
      k_valid <= cc_valid[AF];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_pay <= k_pay_next;
      k_t <= t_in;
    end
  end

  // forward: rounded numerators for amplitude and phase
  logic          n_valid;
  spq_pkg::pay_t n_pay;
  spq_pkg::pay_t n_pay_next;
  logic [63:0]   n_rem;
  logic [63:0]   num_a;
  logic [63:0]   t_u;

  always_comb begin
    num_a = 64'($unsigned(k_pay.y)) + 64'($unsigned(k_pay.x)) + (64'(wh) << 15);
    t_u = 64'(k_t[ZW-1:0]);
    n_pay_next = k_pay;
    if (!inverse_mode) begin
      n_pay_next.x = $signed(XW'(num_a));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (adv) begin
      n_valid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_pay <= n_pay_next;
      n_rem <= (t_u << 16) - t_u + (TWOPI_AF >> 1);
    end
  end

  // phase word: reciprocal estimate, at most one short
  logic          p1_valid;
  spq_pkg::pay_t p1_pay;
  logic [63:0]   p1_rem;
  logic [QW-1:0] p1_q;
  logic [63:0]   ph_prod;

  assign ph_prod = (n_rem >> 16) * PH_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_pay <= n_pay;
      p1_rem <= n_rem;
      p1_q <= QW'(ph_prod >> (AF + 7));
    end
  end

  // phase word: one compare and step up
  logic          p2_valid;
  spq_pkg::pay_t p2_pay;
  logic [QW-1:0] p2_q;
  logic [63:0]   ph_back;
  logic [63:0]   ph_left;

  assign ph_back = 64'(p1_q) * TWOPI_AF;
  assign ph_left = p1_rem - ph_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_pay <= p1_pay;
      p2_q <= p1_q + QW'(ph_left >= TWOPI_AF);
    end
  end

  // amplitude division row; phase quotient rides along in y
  logic          ac_valid [QW+1];
  logic [63:0]   ac_rem   [QW+1];
  logic [QW-1:0] ac_q     [QW+1];
  spq_pkg::pay_t ac_pay   [QW+1];
  logic [63:0]   amp_div;

  assign amp_div = 64'(wh) << 16;

  always_comb begin
    ac_pay[0] = p2_pay;
    ac_rem[0] = '0;
    if (!inverse_mode) begin
      ac_pay[0].y = $signed(XW'(p2_q));
      ac_rem[0] = 64'($unsigned(p2_pay.x));
    end
  end

  assign ac_valid[0] = p2_valid;
  assign ac_q[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_adiv
    spq_div_cell #(
      .BIT (QW - 1 - k),
      .QW  (QW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (ac_valid[k]),
      .in_rem    (ac_rem[k]),
      .in_q      (ac_q[k]),
      .divisor   (amp_div),
      .in_pay    (ac_pay[k]),
      .out_valid (ac_valid[k+1]),
      .out_rem   (ac_rem[k+1]),
      .out_q     (ac_q[k+1]),
      .out_pay   (ac_pay[k+1])
    );
  end

  // output register: clamp words or round the rebuilt parts
  spq_pkg::pay_t fin;
  logic [QW-1:0] amp_q;

  assign fin = ac_pay[QW];
  assign amp_q = ac_q[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ac_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dest_column <= fin.side.dcol;
      dest_row <= fin.side.drow;
      if (inverse_mode) begin
        amplitude_word_out <= '0;
        phase_word_out <= '0;
        real_out <= $signed(spq_pkg::round_out41(fin.x));
        imag_out <= $signed(spq_pkg::round_out41(fin.y));
      end else begin
        amplitude_word_out <= amp_q[QW-1] ? 16'hFFFF : amp_q[15:0];
        if (fin.flag) begin
          phase_word_out <= '0;
        end else begin
          phase_word_out <= fin.y[QW-1] ? 16'hFFFF : fin.y[15:0];
        end
        real_out <= '0;
        imag_out <= '0;
      end
    end
  end

  // checks
  logic words_zero;
  logic parts_zero;
  assign words_zero = (amplitude_word_out == '0) && (phase_word_out == '0);
  assign parts_zero = (real_out == '0) && (imag_out == '0);

  `SPQ_ASSERT_NOW(a_hold_stalls_input, clk, rst, out_valid && out_stall, in_stall)
  `SPQ_ASSERT_NOW(a_inverse_words_zero, clk, rst, out_valid && inverse_mode, words_zero)
  `SPQ_ASSERT_NOW(a_forward_parts_zero, clk, rst, out_valid && !inverse_mode, parts_zero)
  `SPQ_ASSERT_NEXT(a_held_result_stays, clk, rst, out_valid && out_stall, out_valid && $stable(amplitude_word_out) && $stable(real_out))

endmodule

// File: tb/spectrum_polar_quantizer_top_tb.sv
module spectrum_polar_quantizer_top_tb;

  localparam int AF = 24;
  localparam int GB = 16;
  localparam longint unsigned KINV = 64'h9B74EDA8;

  typedef struct {
    logic [11:0]        dcol;
    logic [11:0]        drow;
    logic [15:0]        amp;
    logic [15:0]        phase;
    logic signed [40:0] re;
    logic signed [40:0] im;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] column = '0;
  logic [11:0] row = '0;
  logic signed [40:0] real_part = '0;
  logic signed [40:0] imag_part = '0;
  logic [15:0] amplitude_word_in = '0;
  logic [15:0] phase_word_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] dest_column;
  logic [11:0] dest_row;
  logic [15:0] amplitude_word_out;
  logic [15:0] phase_word_out;
  logic signed [40:0] real_out;
  logic signed [40:0] imag_out;

  spectrum_polar_quantizer_top dut (.*);

  always #2 clk = ~clk;

  // shadow of the configuration registers
  logic [12:0] cur_width = 13'd1024;
  logic [12:0] cur_height = 13'd1024;
  logic cur_centered = 1'b1;
  logic cur_inverse = 1'b0;

  // angle constants in q24
  longint signed arctan_q[AF];
  longint signed pi_q, half_pi_q, two_pi_q;

  bin_result_t pending_bins[$];
  int errors = 0;
  int results_seen = 0;
  int fwd_sent = 0;
  int inv_sent = 0;
  int phases = 0;

  function automatic longint unsigned arctan_recip(longint unsigned n);
    longint unsigned t, sum, nn, term;
    int m;
    bit neg;
    t = (64'd1 << 60) / n;
    sum = t;
    nn = n * n;
    m = 1;
    neg = 1'b1;
    while (1) begin
      t = t / nn;
      if (t == 0) break;
      term = t / longint'(2 * m + 1);
      sum = neg ? sum - term : sum + term;
      neg = !neg;
      m++;
    end
    return sum;
  endfunction

  function automatic longint unsigned arctan_pow2(int k);
    longint unsigned sum, term;
    int m;
    bit neg;
    sum = 0;
    m = 0;
    neg = 1'b0;
    while (k * (2 * m + 1) <= 60) begin
      term = (64'd1 << (60 - k * (2 * m + 1))) / longint'(2 * m + 1);
      sum = neg ? sum - term : sum + term;
      neg = !neg;
      m++;
    end
    return sum;
  endfunction

  function automatic longint signed q60_to_q24(longint unsigned q);
    return longint'((q + (64'd1 << (59 - AF))) >> (60 - AF));
  endfunction

  // floor(v * kinv / 2^s) split to stay in 64 bits
  function automatic longint unsigned gain_scale(longint unsigned v, int s);
    longint unsigned hi, lo;
    hi = v >> 32;
    lo = v & 64'hFFFF_FFFF;
    return ((hi * KINV) << (32 - s)) + ((lo * KINV) >> s);
  endfunction

  function automatic logic [11:0] quadrant_swap(logic [11:0] c, logic [12:0] size);
    longint unsigned half, r;
    half = size / 2;
    r = c;
    if (cur_centered) r = (c < half) ? c + half : c - half;
    return 12'(r % 4096);
  endfunction

  function automatic logic signed [40:0] drop_guard(longint signed v);
    longint signed r;
    r = (v + (64'sd1 << (GB - 1))) >>> GB;
    if (r > (64'sd1 << 40) - 1) r = (64'sd1 << 40) - 1;
    if (r < -(64'sd1 << 40)) r = -(64'sd1 << 40);
    return r[40:0];
  endfunction

  function automatic bin_result_t predict_bin(logic [11:0] col, logic [11:0] rw,
                                              logic signed [40:0] re, logic signed [40:0] im,
                                              logic [15:0] aw, logic [15:0] pw);
    bin_result_t res;
    longint unsigned w, h, m, d, amp, word, tw;
    longint signed x, y, z, t, xs, ys, mag;
    w = (cur_width != 0) ? cur_width : 1;
    h = (cur_height != 0) ? cur_height : 1;
    res.dcol = quadrant_swap(col, cur_width);
    res.drow = quadrant_swap(rw, cur_height);
    res.amp = '0;
    res.phase = '0;
    res.re = '0;
    res.im = '0;
    if (!cur_inverse) begin
      x = longint'(re) * (64'sd1 << GB);
      y = longint'(im) * (64'sd1 << GB);
      z = 0;
      amp = 0;
      if (x != 0 || y != 0) begin
        // left half plane gets a quarter turn first
        if (x < 0) begin
          t = x;
          if (y >= 0) begin
            x = y; y = -t; z = half_pi_q;
          end else begin
            x = -y; y = t; z = -half_pi_q;
          end
        end
        for (int i = 0; i < AF; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x += ys; y -= xs; z += arctan_q[i];
          end else begin
            x -= ys; y += xs; z -= arctan_q[i];
          end
        end
        m = gain_scale(longint'(x), 32);
        d = (w * h) << GB;
        amp = (m + d / 2) / d;
        if (amp > 65535) amp = 65535;
      end
      t = z + pi_q;
      if (t < 0) begin
        word = 0;
      end else begin
        tw = two_pi_q;
        word = (longint'(t) * 65535 + tw / 2) / tw;
        if (word > 65535) word = 65535;
      end
      res.amp = amp[15:0];
      res.phase = word[15:0];
    end else begin
      m = longint'(aw) * w * h;
      mag = gain_scale(m, 32 - GB);
      z = longint'((longint'(pw) * longint'(two_pi_q) + 32767) / 64'd65535) - pi_q;
      // angles beyond a quarter turn are folded back first
      if (z > half_pi_q) begin
        x = 0; y = mag; z -= half_pi_q;
      end else if (z < -half_pi_q) begin
        x = 0; y = -mag; z += half_pi_q;
      end else begin
        x = mag; y = 0;
      end
      for (int i = 0; i < AF; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= arctan_q[i];
        end else begin
          x += ys; y -= xs; z += arctan_q[i];
        end
      end
      res.re = drop_guard(x);
      res.im = drop_guard(y);
    end
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    bin_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_bins.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = pending_bins.pop_front();
        if (e.dcol !== dest_column || e.drow !== dest_row || e.amp !== amplitude_word_out ||
            e.phase !== phase_word_out || e.re !== real_out || e.im !== imag_out) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t: exp col %0d row %0d amp %0d ph %0d re %0d im %0d",
                     $realtime, e.dcol, e.drow, e.amp, e.phase, e.re, e.im);
            $display("               got col %0d row %0d amp %0d ph %0d re %0d im %0d",
                     dest_column, dest_row, amplitude_word_out, phase_word_out,
                     real_out, imag_out);
          end
        end
      end
    end
  end

  // output stall: calm stretches, short bursts, a few long holds
  int stall_left = 0;
  int cyc = 0;
  always @(posedge clk) begin
    int r;
    cyc++;
    r = $urandom_range(0, 99);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ((cyc % 700) < 150 || r < 65) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      out_stall <= 1'b1;
    end
  end

  task automatic write_reg(spq_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      spq_pkg::REG_FRAME_WIDTH:    cur_width = value[12:0];
      spq_pkg::REG_FRAME_HEIGHT:   cur_height = value[12:0];
      spq_pkg::REG_CENTERED_ORDER: cur_centered = value[0];
      spq_pkg::REG_INVERSE_MODE:   cur_inverse = value[0];
    endcase
  endtask

  // hold off until every expected bin is back and the pipe is empty
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic set_frame(logic [12:0] w, logic [12:0] h, logic c, logic inv);
    drain();
    write_reg(spq_pkg::REG_FRAME_WIDTH, 32'(w));
    write_reg(spq_pkg::REG_FRAME_HEIGHT, 32'(h));
    write_reg(spq_pkg::REG_CENTERED_ORDER, 32'(c));
    write_reg(spq_pkg::REG_INVERSE_MODE, 32'(inv));
    phases++;
  endtask

  // one input transfer followed by a random gap
  task automatic send_bin(logic [11:0] col, logic [11:0] rw, logic signed [40:0] re,
                          logic signed [40:0] im, logic [15:0] aw, logic [15:0] pw);
    int r, gap;
    in_valid <= 1'b1;
    column <= col;
    row <= rw;
    real_part <= re;
    imag_part <= im;
    amplitude_word_in <= aw;
    phase_word_in <= pw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_bins.push_back(predict_bin(col, rw, re, im, aw, pw));
    if (cur_inverse) inv_sent++;
    else fwd_sent++;
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [40:0] rand_part();
    logic signed [40:0] v;
    v = 41'({$urandom, $urandom});
    return v >>> $urandom_range(0, 40);
  endfunction

  function automatic logic [11:0] rand_coord();
    return 12'($urandom);
  endfunction

  localparam logic signed [40:0] PMAX = {1'b0, {40{1'b1}}};
  localparam logic signed [40:0] PMIN = {1'b1, 40'd0};

  task automatic test_forward_directed;
    set_frame(13'd1024, 13'd1024, 1'b1, 1'b0);
    send_bin(12'd0, 12'd0, 41'sd0, 41'sd0, 16'hFFFF, 16'hFFFF);
    send_bin(12'd511, 12'd512, PMAX, 41'sd0, '0, '0);
    send_bin(12'd4095, 12'd1023, PMIN, 41'sd0, '0, '0);
    send_bin(12'd1024, 12'd0, PMIN, -41'sd1, '0, '0);
    send_bin(12'd3000, 12'd100, 41'sd0, PMAX, '0, '0);
    send_bin(12'd7, 12'd9, 41'sd0, PMIN, '0, '0);
    send_bin(12'd1, 12'd2, PMAX, PMAX, '0, '0);
    send_bin(12'd3, 12'd4, PMIN, PMIN, '0, '0);
    send_bin(12'd5, 12'd6, -41'sd1, 41'sd0, '0, '0);
    send_bin(12'd8, 12'd8, 41'sd1, -41'sd1, '0, '0);
  endtask

  task automatic test_inverse_directed;
    set_frame(13'd8191, 13'd8191, 1'b0, 1'b1);
    send_bin(12'd0, 12'd4095, PMAX, PMIN, 16'd0, 16'd0);
    send_bin(12'd4095, 12'd0, '0, '0, 16'hFFFF, 16'd0);
    send_bin(12'd10, 12'd20, '0, '0, 16'hFFFF, 16'hFFFF);
    send_bin(12'd30, 12'd40, '0, '0, 16'hFFFF, 16'd32767);
    send_bin(12'd50, 12'd60, '0, '0, 16'd1, 16'd32768);
    send_bin(12'd70, 12'd80, '0, '0, 16'd1000, 16'd16384);
    send_bin(12'd90, 12'd99, '0, '0, 16'd1000, 16'd49151);
    set_frame(13'd0, 13'd0, 1'b1, 1'b1);
    send_bin(12'd0, 12'd4095, '0, '0, 16'hFFFF, 16'd12345);
    send_bin(12'd2048, 12'd1, '0, '0, 16'd1, 16'd54321);
  endtask

  task automatic run_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) send_bin(rand_coord(), rand_coord(), 41'sd0, 41'sd0, 16'($urandom),
                          16'($urandom));
      else if (r < 12) send_bin(rand_coord(), rand_coord(), r[0] ? PMAX : PMIN,
                                r[1] ? PMAX : PMIN, 16'hFFFF, 16'($urandom_range(0, 1)));
      else send_bin(rand_coord(), rand_coord(), rand_part(), rand_part(), 16'($urandom),
                    16'($urandom));
    end
  endtask

  task automatic test_random_frames;
    set_frame(13'd4096, 13'd4096, 1'b1, 1'b0);
    run_random(200);
    set_frame(13'd1, 13'd1, 1'b0, 1'b0);
    run_random(200);
    set_frame(13'd7, 13'd13, 1'b1, 1'b0);
    run_random(200);
    set_frame(13'($urandom), 13'($urandom), 1'b1, 1'b0);
    run_random(200);
    set_frame(13'd4096, 13'd4096, 1'b1, 1'b1);
    run_random(200);
    set_frame(13'd1, 13'd1, 1'b0, 1'b1);
    run_random(200);
    set_frame(13'd8191, 13'd2, 1'b1, 1'b1);
    run_random(150);
    set_frame(13'($urandom), 13'($urandom), 1'b1, 1'b1);
    run_random(150);
  endtask

  // run limit
  initial begin
    #4000000;
    $display("FAIL spectrum_polar_quantizer_top");
    $finish;
  end

  initial begin
    longint unsigned quarter;
    quarter = 4 * arctan_recip(5) - arctan_recip(239);
    arctan_q[0] = q60_to_q24(quarter);
    for (int k = 1; k < AF; k++) arctan_q[k] = q60_to_q24(arctan_pow2(k));
    pi_q = q60_to_q24(4 * quarter);
    half_pi_q = q60_to_q24(2 * quarter);
    two_pi_q = q60_to_q24(8 * quarter);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_forward_directed();
    test_inverse_directed();
    test_random_frames();
    drain();
    if (pending_bins.size() != 0) errors++;
    $display("covered %0d forward and %0d inverse transfers over %0d register settings",
             fwd_sent, inv_sent, phases);
    $display("%0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("PASS spectrum_polar_quantizer_top");
    end else begin
      $display("FAIL spectrum_polar_quantizer_top");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_div_cell.sv
hw/rtl/spq_cordic_cell.sv
hw/rtl/spectrum_polar_quantizer_top.sv
tb/spectrum_polar_quantizer_top_tb.sv
